FILE: design/lrsp_pkg.sv
// Shared types and constants for the least-recent server picker.
// No dependencies; used by least_recent_server_picker.
package lrsp_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;
    // At most 16 slots can be addressed; candidate masks are 16 bits wide.
    localparam int ADDR_MAX      = 16;
    localparam int SLOT_W        = 4;
    localparam int COUNT_W       = 5;
    localparam int MAX_OUT       = 16;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_CONTACT = 2'd1;
    localparam logic [1:0] KIND_DEAD    = 2'd2;
    localparam logic [1:0] KIND_SELECT  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

FILE: design/least_recent_server_picker.sv
// Least-recent server picker: slot table, time counter and selection sequencer; uses lrsp_pkg.
// Tick, contact and dead requests are taken one per cycle while the picker is idle. With A = min(SLOTS, 16), a select
// counts candidates over the A slots after acceptance, then for each chosen slot runs the
// minimum search over the A slots (one key per cycle, single comparator) and hands the
// result over; ready stays low from the select's acceptance until its last result is taken.
// rst_n (async, active low) clears the time counter, the contacted and dead flags and the sequencer.
module least_recent_server_picker #(
    parameter int SLOTS     = lrsp_pkg::SLOTS_DEF,
    parameter int TIME_BITS = lrsp_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] server_slot, [19:4] candidate_mask, [20] allow_dead,
    // [25:21] select_count, [31:26] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] chosen_slot, [7:4] zero
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // [0] none_selected
    output logic [0:0]  m_axis_tuser
);

    // Only the first 16 slots can ever be addressed or offered.
    localparam int ADDR_SLOTS = (SLOTS < lrsp_pkg::ADDR_MAX) ? SLOTS : lrsp_pkg::ADDR_MAX;
    localparam int IDX_W      = $clog2(ADDR_SLOTS);
    localparam int SLOT_W     = lrsp_pkg::SLOT_W;
    localparam int COUNT_W    = lrsp_pkg::COUNT_W;
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(ADDR_SLOTS - 1);
    localparam logic [SLOT_W:0]    ADDR_LIM = (SLOT_W + 1)'(ADDR_SLOTS);
    localparam logic [COUNT_W-1:0] CNT_CAP  = COUNT_W'(lrsp_pkg::MAX_OUT);

    // request fields
    logic [SLOT_W-1:0]  in_slot;
    logic [15:0]        in_mask;
    logic               in_allow;
    logic [COUNT_W-1:0] in_count;
    logic               in_acc;
    logic               slot_ok;

    assign in_slot  = s_axis_tdata[3:0];
    assign in_mask  = s_axis_tdata[19:4];
    assign in_allow = s_axis_tdata[20];
    assign in_count = s_axis_tdata[25:21];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign slot_ok  = {1'b0, in_slot} < ADDR_LIM;

    // slot table
    logic [TIME_BITS-1:0]  current_time_reg, current_time_next;
    logic [TIME_BITS-1:0]  contact_time_reg [ADDR_SLOTS];
    logic [ADDR_SLOTS-1:0] contacted_reg, contacted_next;
    logic [ADDR_SLOTS-1:0] dead_reg, dead_next;
    logic                  ts_we;

    // sequencer
    lrsp_pkg::state_t      state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [ADDR_SLOTS-1:0] cand_reg, cand_next;
    logic [ADDR_SLOTS-1:0] pool_reg, pool_next;
    logic                  allow_reg, allow_next;
    logic [COUNT_W-1:0]    cnt_reg, cnt_next;
    logic [COUNT_W-1:0]    n_reg, n_next;
    logic [COUNT_W-1:0]    alive_reg, alive_next;
    logic [COUNT_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [TIME_BITS-1:0]  best_key_reg, best_key_next;
    logic                  found_reg, found_next;

    // result register
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_none_reg, out_none_next;

    // scan helpers
    logic [TIME_BITS-1:0]  key;
    logic                  take;
    logic [ADDR_SLOTS-1:0] alive_mask;
    logic [ADDR_SLOTS-1:0] pool_left;
    logic                  scan_end;
    logic                  count_end;
    logic                  out_acc;

    assign out_acc    = m_axis_tvalid && m_axis_tready;
    assign scan_end   = (state_reg == lrsp_pkg::ST_SCAN) && (idx_reg == IDX_LAST);
    assign count_end  = (state_reg == lrsp_pkg::ST_COUNT) && (idx_reg == IDX_LAST);
    assign alive_mask = cand_reg & ~dead_reg;

    // Key of the slot under the comparator; never-contacted slots count as now.
    assign key  = contacted_reg[idx_reg] ? contact_time_reg[idx_reg] : current_time_reg;
    assign take = pool_reg[idx_reg] && (!found_reg || (key < best_key_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrsp_pkg::ST_IDLE:
            begin
                if (in_acc && (s_axis_tuser == lrsp_pkg::KIND_SELECT))
                begin
                    state_next = lrsp_pkg::ST_COUNT;
                end
            end
            lrsp_pkg::ST_COUNT:
            begin
                if (count_end)
                begin
                    if ((cnt_reg == '0) || (n_next == '0))
                    begin
                        state_next = lrsp_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = lrsp_pkg::ST_SCAN;
                    end
                end
            end
            lrsp_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = lrsp_pkg::ST_EMIT;
                end
            end
            lrsp_pkg::ST_EMIT:
            begin
                if (out_acc)
                begin
                    state_next = out_last_reg ? lrsp_pkg::ST_IDLE : lrsp_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = lrsp_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        current_time_next = current_time_reg;
        contacted_next    = contacted_reg;
        dead_next         = dead_reg;
        ts_we             = 1'b0;
        idx_next          = idx_reg;
        cand_next         = cand_reg;
        pool_next         = pool_reg;
        allow_next        = allow_reg;
        cnt_next          = cnt_reg;
        n_next            = n_reg;
        alive_next        = alive_reg;
        k_next            = k_reg;
        best_next         = best_reg;
        best_key_next     = best_key_reg;
        found_next        = found_reg;
        out_slot_next     = out_slot_reg;
        out_last_next     = out_last_reg;
        out_none_next     = out_none_reg;
        pool_left         = pool_reg;

        s_axis_tready = (state_reg == lrsp_pkg::ST_IDLE);
        m_axis_tvalid = (state_reg == lrsp_pkg::ST_EMIT);
        m_axis_tdata  = {{(8 - SLOT_W){1'b0}}, out_slot_reg};
        m_axis_tlast  = out_last_reg;
        m_axis_tuser  = out_none_reg;

        unique case (state_reg)
            lrsp_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (s_axis_tuser)
                        lrsp_pkg::KIND_TICK:
                        begin
                            if (!(&current_time_reg))
                            begin
                                current_time_next = current_time_reg + TIME_BITS'(1);
                            end
                        end
                        lrsp_pkg::KIND_CONTACT:
                        begin
                            if (slot_ok)
                            begin
                                ts_we = 1'b1;
                                contacted_next[in_slot[IDX_W-1:0]] = 1'b1;
                            end
                        end
                        lrsp_pkg::KIND_DEAD:
                        begin
                            if (slot_ok)
                            begin
                                dead_next[in_slot[IDX_W-1:0]] = 1'b1;
                            end
                        end
                        lrsp_pkg::KIND_SELECT:
                        begin
                            cand_next  = in_mask[ADDR_SLOTS-1:0];
                            allow_next = in_allow;
                            cnt_next   = (in_count > CNT_CAP) ? CNT_CAP : in_count;
                            n_next     = '0;
                            alive_next = '0;
                            k_next     = '0;
                            idx_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lrsp_pkg::ST_COUNT:
            begin
                // One slot per cycle: candidates and live candidates.
                n_next     = n_reg + COUNT_W'(cand_reg[idx_reg]);
                alive_next = alive_reg + COUNT_W'(alive_mask[idx_reg]);
                idx_next   = IDX_W'(idx_reg + 1'b1);
                if (count_end)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    if ((cnt_reg == '0) || (n_next == '0))
                    begin
                        out_slot_next = '0;
                        out_last_next = 1'b1;
                        out_none_next = 1'b1;
                    end
                    else if ((n_next > cnt_reg) && !allow_reg && (alive_next > cnt_reg))
                    begin
                        pool_next = alive_mask;
                    end
                    else
                    begin
                        pool_next = cand_reg;
                    end
                end
            end
            lrsp_pkg::ST_SCAN:
            begin
                // Running minimum; strict compare keeps the lower slot on ties.
                if (take)
                begin
                    best_next     = idx_reg;
                    best_key_next = key;
                    found_next    = 1'b1;
                end
                idx_next = IDX_W'(idx_reg + 1'b1);
                if (scan_end)
                begin
                    pool_left     = pool_reg & ~(ADDR_SLOTS'(1) << best_next);
                    pool_next     = pool_left;
                    k_next        = COUNT_W'(k_reg + 1'b1);
                    out_slot_next = SLOT_W'(best_next);
                    out_none_next = 1'b0;
                    out_last_next = (k_next == cnt_reg) || (pool_left == '0);
                end
            end
            lrsp_pkg::ST_EMIT:
            begin
                if (out_acc)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lrsp_pkg::ST_IDLE;
            current_time_reg <= '0;
            contacted_reg    <= '0;
            dead_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            current_time_reg <= current_time_next;
            contacted_reg    <= contacted_next;
            dead_reg         <= dead_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ts_we)
        begin
            contact_time_reg[in_slot[IDX_W-1:0]] <= current_time_reg;
        end
    end

    // payload and sequencer working registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cand_reg     <= cand_next;
        pool_reg     <= pool_next;
        allow_reg    <= allow_next;
        cnt_reg      <= cnt_next;
        n_reg        <= n_next;
        alive_reg    <= alive_next;
        k_reg        <= k_next;
        best_reg     <= best_next;
        best_key_reg <= best_key_next;
        found_reg    <= found_next;
        out_slot_reg <= out_slot_next;
        out_last_reg <= out_last_next;
        out_none_reg <= out_none_next;
    end

    // One request in flight: no new request while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while a result is pending");

    // An empty selection is always the final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("empty selection not marked last");

    // Never more results than requested.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> ((k_reg <= cnt_reg) && (k_reg != '0)))
        else $error("selection count exceeded");

    // The time counter never goes backwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (current_time_reg >= $past(current_time_reg)))
        else $error("time counter went backwards");

endmodule
